### rtl/trob_pkg.sv
package trob_pkg;

   localparam int unsigned REG_COUNT      = 13;
   localparam logic [3:0]  REG_MAX_INDEX  = 4'd12;
   localparam int unsigned REG_IDX_W      = 4;
   localparam int unsigned DATA_W         = 64;

   // request kinds
   localparam logic REQ_BRANCH = 1'b0;
   localparam logic REQ_WRITE  = 1'b1;

   typedef enum logic [2:0] {
      COND_EQ   = 3'd0,
      COND_NE   = 3'd1,
      COND_LT_U = 3'd2,
      COND_LT_S = 3'd3,
      COND_GE_U = 3'd4,
      COND_GE_S = 3'd5
   } cond_type;

   typedef struct packed {
      logic        req_type;
      logic [2:0]  condition;
      logic [39:0] operand_bytes;
      logic [7:0]  operand_length;
      logic [63:0] current_pc;
      logic [3:0]  write_index;
      logic [63:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic        branch_taken;
      logic [63:0] branch_target;
      logic [63:0] next_pc;
   } rsp_item_type;

   // register file port controls
   typedef struct packed {
      logic                 rd_en;
      logic [REG_IDX_W-1:0] rd_a;
      logic [REG_IDX_W-1:0] rd_b;
      logic                 wr_en;
      logic [REG_IDX_W-1:0] wr_idx;
      logic [DATA_W-1:0]    wr_data;
   } rf_req_type;

endpackage

### rtl/trob_regfile.sv
module trob_regfile (
   input  logic                          clock,
   input  logic                          reset,
   input  trob_pkg::rf_req_type          rf_req,
   output logic [trob_pkg::DATA_W-1:0]   rd_data_a,
   output logic [trob_pkg::DATA_W-1:0]   rd_data_b
);

   logic [trob_pkg::DATA_W-1:0] mem [trob_pkg::REG_COUNT];
   logic [trob_pkg::REG_COUNT-1:0] valid_ff;
   logic [trob_pkg::DATA_W-1:0] rd_a_ff;
   logic [trob_pkg::DATA_W-1:0] rd_b_ff;
   logic rd_a_valid_ff;
   logic rd_b_valid_ff;
   logic wr_ok;

   // drop writes to indices past the last register
   assign wr_ok = rf_req.wr_en &&
                  (rf_req.wr_idx <= trob_pkg::REG_MAX_INDEX);

   // store write data
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[rf_req.wr_idx] <= rf_req.wr_data;
      end
   end

   // track written entries, unwritten ones read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[rf_req.wr_idx] <= 1'b1;
      end
   end

   // registered read of both ports
   always_ff @(posedge clock) begin
      if (rf_req.rd_en) begin
         rd_a_ff <= mem[rf_req.rd_a];
         rd_b_ff <= mem[rf_req.rd_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_a_valid_ff <= 1'b0;
         rd_b_valid_ff <= 1'b0;
      end else if (rf_req.rd_en) begin
         rd_a_valid_ff <= valid_ff[rf_req.rd_a];
         rd_b_valid_ff <= valid_ff[rf_req.rd_b];
      end
   end

   assign rd_data_a = rd_a_valid_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_b_valid_ff ? rd_b_ff : '0;

   // read addresses are already clamped to the last register
   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      rf_req.rd_en |-> (rf_req.rd_a <= trob_pkg::REG_MAX_INDEX &&
                        rf_req.rd_b <= trob_pkg::REG_MAX_INDEX))
      else $error("register file read address out of range");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(rf_req.rd_en && rf_req.wr_en))
      else $error("register file read and write in one cycle");

   a_wr_then_rd: assert property (@(posedge clock) disable iff (reset)
      wr_ok ##1 (rf_req.rd_en && rf_req.rd_a == $past(rf_req.wr_idx))
      |=> rd_data_a == $past(rf_req.wr_data, 2))
      else $error("read after write returned stale data");

endmodule

### rtl/two_reg_offset_branch_unit_top.sv
// Compare-and-branch unit with a 13-entry 64-bit register file.
// Input channel req_*: each item is either a register write (req_type
// set) or a branch instruction. A write stores write_value at write_index
// (indices past 12 are dropped) and produces no result. A branch reads two
// registers named by operand byte zero, compares them by condition and
// returns one rsp_* item: taken flag, pc-relative target and next pc.
// An item is taken when valid is high and stall is low.
// A branch result reaches rsp_valid through the operand stage: the
// register-file read and the operand stage load at the accepting edge,
// and the compare and the two 64-bit adds go into the output register
// once the output register is not blocked by a held result.
// Throughput: one item per cycle while req_stall is low, set by the single
// read port pair of the register file and the one-deep operand stage.
// Reset clears all control state and marks every register as zero.
// When the receiver stalls, the result holds in the output register and
// one more branch may sit in the operand stage; after that req_stall rises
// until the result is taken.
module two_reg_offset_branch_unit_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  trob_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output trob_pkg::rsp_item_type rsp_data
);

   logic req_take;
   logic is_branch;
   logic out_blocked;
   logic [7:0] b0;
   logic [3:0] idx_a;
   logic [3:0] idx_b;
   trob_pkg::rf_req_type rf_req;
   logic [63:0] rd_data_a;
   logic [63:0] rd_data_b;

   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_cond_ff;
   logic [39:0] s1_ops_ff;
   logic [7:0]  s1_len_ff;
   logic [63:0] s1_pc_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   trob_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic [63:0] offset;
   logic [63:0] target;
   logic [63:0] fall;
   logic        taken;

   // handshake
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = s1_valid_ff && out_blocked;
   assign req_take    = req_valid && !req_stall;
   assign is_branch   = (req_data.req_type == trob_pkg::REQ_BRANCH);

   // decode register indices, empty operands read register zero
   assign b0 = (req_data.operand_length != 8'd0) ? req_data.operand_bytes[7:0] : 8'd0;
   assign idx_a = (b0[3:0] > trob_pkg::REG_MAX_INDEX) ? trob_pkg::REG_MAX_INDEX : b0[3:0];
   assign idx_b = (b0[7:4] > trob_pkg::REG_MAX_INDEX) ? trob_pkg::REG_MAX_INDEX : b0[7:4];

   always_comb begin
      rf_req.rd_en   = req_take && is_branch;
      rf_req.rd_a    = idx_a;
      rf_req.rd_b    = idx_b;
      rf_req.wr_en   = req_take && !is_branch;
      rf_req.wr_idx  = req_data.write_index;
      rf_req.wr_data = req_data.write_value;
   end

   trob_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rf_req    (rf_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // operand stage: advance unless blocked behind a held result
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!s1_valid_ff || !out_blocked) begin
         s1_valid_in = req_take && is_branch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && is_branch) begin
         s1_cond_ff <= req_data.condition;
         s1_ops_ff  <= req_data.operand_bytes;
         s1_len_ff  <= req_data.operand_length;
         s1_pc_ff   <= req_data.current_pc;
      end
   end

   // sign-extend the little-endian offset
   always_comb begin
      if (s1_len_ff >= 8'd5) begin
         offset = {{32{s1_ops_ff[39]}}, s1_ops_ff[39:8]};
      end else begin
         case (s1_len_ff)
            8'd2:    offset = {{56{s1_ops_ff[15]}}, s1_ops_ff[15:8]};
            8'd3:    offset = {{48{s1_ops_ff[23]}}, s1_ops_ff[23:8]};
            8'd4:    offset = {{40{s1_ops_ff[31]}}, s1_ops_ff[31:8]};
            default: offset = '0;
         endcase
      end
   end

   // compare the two registers
   always_comb begin
      unique case (s1_cond_ff)
         trob_pkg::COND_EQ:   taken = (rd_data_a == rd_data_b);
         trob_pkg::COND_NE:   taken = (rd_data_a != rd_data_b);
         trob_pkg::COND_LT_U: taken = (rd_data_a < rd_data_b);
         trob_pkg::COND_LT_S: taken = ($signed(rd_data_a) < $signed(rd_data_b));
         trob_pkg::COND_GE_U: taken = (rd_data_a >= rd_data_b);
         trob_pkg::COND_GE_S: taken = ($signed(rd_data_a) >= $signed(rd_data_b));
         default:             taken = 1'b0;
      endcase
   end

   assign target = s1_pc_ff + offset;
   assign fall   = s1_pc_ff + 64'd1 + {56'd0, s1_len_ff};

   always_comb begin
      rsp_data_in.branch_taken  = taken;
      rsp_data_in.branch_target = target;
      rsp_data_in.next_pc       = taken ? target : fall;
   end

   // output register: hold while the receiver stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!out_blocked) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_blocked && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled without a held result");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_blocked) |=> rsp_valid_ff)
      else $error("operand stage item lost");

   a_load_pc: assert property (@(posedge clock) disable iff (reset)
      (req_take && is_branch) |=> (s1_valid_ff && s1_pc_ff == $past(req_data.current_pc)))
      else $error("branch item not captured");

   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_take && !is_branch && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("register write produced a result");

endmodule

### sim/two_reg_offset_branch_unit_top_tb.sv
module two_reg_offset_branch_unit_top_tb;

   // condition codes that the unit treats as never taken
   localparam logic [2:0] COND_RSVD_6 = 3'd6;
   localparam logic [2:0] COND_RSVD_7 = 3'd7;

   localparam int RANDOM_ITEMS  = 1950;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      trob_pkg::req_item_type item;
      bit                     drain_first;
   } staged_item_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   trob_pkg::req_item_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   trob_pkg::rsp_item_type rsp_data;

   logic [63:0]            shadow_regs [trob_pkg::REG_COUNT];
   staged_item_type        instr_queue[$];
   trob_pkg::rsp_item_type branch_results[$];
   int                     staged_count   = 0;
   int                     accepted_items = 0;
   int                     error_count    = 0;
   int                     cycle_count    = 0;
   int                     send_gap       = 0;
   bit                     send_burst     = 1'b0;
   int                     stall_left     = 0;
   bit                     recv_burst     = 1'b0;

   two_reg_offset_branch_unit_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // bias register data toward the compare corners
   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7fff_ffff_ffff_ffff;
         4: return 64'($urandom_range(0, 3));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // random content everywhere, so unused fields toggle too
   function automatic trob_pkg::req_item_type noise_item();
      logic [191:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return bits[$bits(trob_pkg::req_item_type)-1:0];
   endfunction

   function automatic trob_pkg::req_item_type write_item(logic [3:0] idx,
                                                          logic [63:0] val);
      trob_pkg::req_item_type it;
      it             = noise_item();
      it.req_type    = trob_pkg::REQ_WRITE;
      it.write_index = idx;
      it.write_value = val;
      return it;
   endfunction

   function automatic trob_pkg::req_item_type branch_item(logic [2:0] cond,
                                                           logic [39:0] ops,
                                                           logic [7:0] len,
                                                           logic [63:0] pc);
      trob_pkg::req_item_type it;
      it                = noise_item();
      it.req_type       = trob_pkg::REQ_BRANCH;
      it.condition      = cond;
      it.operand_bytes  = ops;
      it.operand_length = len;
      it.current_pc     = pc;
      return it;
   endfunction

   task automatic stage(trob_pkg::req_item_type it, bit drain_first);
      instr_queue.push_back('{it, drain_first});
   endtask

   // apply one accepted item to the shadow file and queue its branch outcome
   task automatic execute_item(trob_pkg::req_item_type it);
      logic [3:0]             ra;
      logic [3:0]             rb;
      logic [63:0]            offset;
      logic [63:0]            a;
      logic [63:0]            b;
      logic                   taken;
      trob_pkg::rsp_item_type outcome;
      if (it.req_type == trob_pkg::REQ_WRITE) begin
         if (it.write_index <= trob_pkg::REG_MAX_INDEX)
            shadow_regs[it.write_index] = it.write_value;
         return;
      end
      ra     = '0;
      rb     = '0;
      offset = '0;
      if (it.operand_length != 0) begin
         ra = (it.operand_bytes[3:0] > trob_pkg::REG_MAX_INDEX) ? trob_pkg::REG_MAX_INDEX
                                                                : it.operand_bytes[3:0];
         rb = (it.operand_bytes[7:4] > trob_pkg::REG_MAX_INDEX) ? trob_pkg::REG_MAX_INDEX
                                                                : it.operand_bytes[7:4];
      end
      // offset width is length minus one bytes, capped at four
      case (it.operand_length)
         8'd0, 8'd1: offset = '0;
         8'd2: offset = {{56{it.operand_bytes[15]}}, it.operand_bytes[15:8]};
         8'd3: offset = {{48{it.operand_bytes[23]}}, it.operand_bytes[23:8]};
         8'd4: offset = {{40{it.operand_bytes[31]}}, it.operand_bytes[31:8]};
         default: offset = {{32{it.operand_bytes[39]}}, it.operand_bytes[39:8]};
      endcase
      a = shadow_regs[ra];
      b = shadow_regs[rb];
      case (it.condition)
         trob_pkg::COND_EQ:   taken = (a == b);
         trob_pkg::COND_NE:   taken = (a != b);
         trob_pkg::COND_LT_U: taken = (a < b);
         trob_pkg::COND_LT_S: taken = ($signed(a) < $signed(b));
         trob_pkg::COND_GE_U: taken = (a >= b);
         trob_pkg::COND_GE_S: taken = ($signed(a) >= $signed(b));
         default:             taken = 1'b0;
      endcase
      outcome.branch_taken  = taken;
      outcome.branch_target = it.current_pc + offset;
      outcome.next_pc       = taken ? outcome.branch_target
                                    : it.current_pc + 64'd1 + 64'(it.operand_length);
      branch_results.push_back(outcome);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // driver: hold the item until accepted, then advance after a random gap
   always @(posedge clock) begin
      bit accepted;
      if (reset) begin
         foreach (shadow_regs[i]) shadow_regs[i] = '0;
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            execute_item(req_data);
            accepted_items++;
         end
         if (!req_valid || accepted) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (instr_queue.size() > 0 &&
                         !(instr_queue[0].drain_first && branch_results.size() > 0)) begin
               req_data  <= instr_queue[0].item;
               req_valid <= 1'b1;
               void'(instr_queue.pop_front());
               if ($urandom_range(0, 149) == 0) send_burst = !send_burst;
               send_gap = send_burst ? 0 : idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted result with the oldest outcome, drive stall
   always @(posedge clock) begin
      trob_pkg::rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (branch_results.size() == 0) begin
               $display("%0t: result with nothing expected: taken %b target %h next %h",
                        $time, rsp_data.branch_taken, rsp_data.branch_target,
                        rsp_data.next_pc);
               error_count++;
            end else begin
               want = branch_results.pop_front();
               check_field("branch_taken", 64'(want.branch_taken),
                           64'(rsp_data.branch_taken));
               check_field("branch_target", want.branch_target, rsp_data.branch_target);
               check_field("next_pc", want.next_pc, rsp_data.next_pc);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            if ($urandom_range(0, 199) == 0) recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : idle_length();
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d items left, %0d results outstanding",
                  $time, instr_queue.size(), branch_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [3:0]  idx;
      logic [2:0]  cond;
      logic [39:0] ops;
      logic [7:0]  len;
      logic [63:0] pc;
      int          roll;

      // load corner values, including writes past the file that must drop
      stage(write_item(4'd1, '1), 1'b0);
      stage(write_item(4'd2, 64'h8000_0000_0000_0000), 1'b0);
      stage(write_item(4'd3, 64'h7fff_ffff_ffff_ffff), 1'b0);
      stage(write_item(4'd12, 64'd5), 1'b0);
      stage(write_item(4'd13, '1), 1'b0);
      stage(write_item(4'd15, 64'd7), 1'b0);
      // empty operands read register zero twice with no offset
      stage(branch_item(trob_pkg::COND_EQ, '1, 8'd0, 64'h100), 1'b0);
      // a single byte names the registers but gives no offset
      stage(branch_item(trob_pkg::COND_NE, 40'h0000000021, 8'd1, 64'h200), 1'b0);
      stage(branch_item(trob_pkg::COND_LT_U, 40'h0000008012, 8'd2, 64'h40), 1'b0);
      stage(branch_item(trob_pkg::COND_LT_S, 40'h00007fff32, 8'd3, 64'h1000), 1'b0);
      stage(branch_item(trob_pkg::COND_GE_U, 40'h0080000013, 8'd4, 64'h0), 1'b0);
      stage(branch_item(trob_pkg::COND_GE_S, 40'h8000000023, 8'd5, 64'h0), 1'b0);
      stage(branch_item(trob_pkg::COND_GE_S, 40'hffffffff11, 8'd5, 64'h10), 1'b0);
      // long operands: four offset bytes, full length on the fall-through
      stage(branch_item(COND_RSVD_6, 40'h7fffffff00, 8'd6, '1), 1'b0);
      stage(branch_item(COND_RSVD_7, 40'h1234567800, 8'd255, '1), 1'b0);
      // nibbles past the file clamp to the last register
      stage(branch_item(trob_pkg::COND_EQ, 40'h00000000df, 8'd1, 64'h300), 1'b0);
      stage(branch_item(trob_pkg::COND_NE, 40'h00000001fc, 8'd2, 64'h400), 1'b0);
      // write then read the same register in consecutive items
      stage(write_item(4'd12, 64'd0), 1'b0);
      stage(branch_item(trob_pkg::COND_EQ, 40'h000000000c, 8'd2, 64'h500), 1'b0);
      stage(branch_item(trob_pkg::COND_LT_U, 40'hffffffffff, 8'd255, '1), 1'b0);

      // random mix, with the sender draining now and then
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 9) < 3) begin
            idx = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(13, 15))
                                              : 4'($urandom_range(0, 12));
            stage(write_item(idx, pick_value()), n == 0 || $urandom_range(0, 299) == 0);
         end else begin
            if ($urandom_range(0, 9) == 0)
               cond = $urandom_range(0, 1) ? COND_RSVD_7 : COND_RSVD_6;
            else
               cond = 3'($urandom_range(trob_pkg::COND_EQ, trob_pkg::COND_GE_S));
            ops  = {8'($urandom), 32'($urandom)};
            roll = $urandom_range(0, 9);
            if (roll < 7)
               len = 8'($urandom_range(0, 6));
            else if (roll < 9)
               len = 8'($urandom_range(7, 20));
            else
               len = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 9);
            if (roll < 7)
               pc = {$urandom, $urandom};
            else if (roll == 7)
               pc = 64'($urandom_range(0, 255));
            else if (roll == 8)
               pc = '1 - 64'($urandom_range(0, 255));
            else
               pc = pick_value();
            stage(branch_item(cond, ops, len, pc), n == 0 || $urandom_range(0, 299) == 0);
         end
      end
      staged_count = instr_queue.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait for every item to go in and every outcome to come back
      while (accepted_items < staged_count || branch_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/trob_pkg.sv
rtl/trob_regfile.sv
rtl/two_reg_offset_branch_unit_top.sv
sim/two_reg_offset_branch_unit_top_tb.sv
